// ===== sv/qgce_pkg.sv =====
package qgce_pkg;

  // One packed pixel: [2] red, [1] green, [0] blue
  typedef logic [2:0][7:0] rgb_t;

  // Four sub-pixels in mask order: [0] TL, [1] TR, [2] BL, [3] BR
  typedef rgb_t [3:0] cell_t;

  // Averaged cell with its per-sub-pixel luma
  typedef struct packed {
    cell_t           sub;
    logic [3:0][7:0] luma;
  } lcell_t;

  localparam int unsigned NUM_PIX = 8;
  localparam int unsigned NUM_SUB = 4;
  localparam int unsigned NUM_CH  = 3;

  localparam logic [17:0] LUMA_R = 18'd299;
  localparam logic [17:0] LUMA_G = 18'd587;
  localparam logic [17:0] LUMA_B = 18'd114;

  // floor(w / 1000) == (w * RECIP_1000) >> RECIP_SHIFT for every w up to 255000
  localparam logic [18:0] RECIP_1000  = 19'd268436;
  localparam int unsigned RECIP_SHIFT = 28;

  // floor(s / 3) == (s * RECIP_3) >> 11 for every s up to 1020
  localparam logic [19:0] RECIP_3 = 20'd683;

  localparam logic [13:0] GLYPH_TABLE [16] = '{
    14'h0020, 14'h2598, 14'h259D, 14'h2580,
    14'h2596, 14'h258C, 14'h259E, 14'h259B,
    14'h2597, 14'h259A, 14'h2590, 14'h259C,
    14'h2584, 14'h2599, 14'h259F, 14'h2588
  };

  // Floor average of two pixels, channel by channel
  function automatic rgb_t pair_avg(input rgb_t a, input rgb_t b);
    rgb_t res;
    logic [8:0] s;
    for (int c = 0; c < NUM_CH; c++) begin
      s = {1'b0, a[c]} + {1'b0, b[c]};
      res[c] = s[8:1];
    end
    return res;
  endfunction

  // Weighted luma sum before the divide by 1000
  function automatic logic [17:0] luma_weight(input rgb_t p);
    return LUMA_R * 18'(p[2]) + LUMA_G * 18'(p[1]) + LUMA_B * 18'(p[0]);
  endfunction

  // Floor mean of a channel sum over a count of one to four; zero for none
  function automatic logic [7:0] div_count(input logic [9:0] s, input logic [2:0] n);
    logic [19:0] prod;
    logic [7:0]  res;
    prod = 20'(s) * RECIP_3;
    case (n)
      3'd1:    res = s[7:0];
      3'd2:    res = s[8:1];
      3'd3:    res = prod[18:11];
      3'd4:    res = s[9:2];
      default: res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/qgce_front.sv =====
module qgce_front
  import qgce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rgb_t [NUM_PIX-1:0]    in_pix,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lcell_t                out_cell
);

  logic [2:0]        v_r;
  logic [2:0]        rdy;
  cell_t             s1_sub_r, s1_sub_nxt;
  cell_t             s2_sub_r;
  logic [3:0][17:0]  s2_w_r, s2_w_nxt;
  lcell_t            s3_cell_r, s3_cell_nxt;

  // Stage advances when empty or when the next one takes its word
  assign rdy[2]   = !v_r[2] || out_ready;
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  // Pair rows: TL from left 0/1, TR right 0/1, BL left 2/3, BR right 2/3
  always_comb begin
    s1_sub_nxt[0] = pair_avg(in_pix[0], in_pix[1]);
    s1_sub_nxt[1] = pair_avg(in_pix[4], in_pix[5]);
    s1_sub_nxt[2] = pair_avg(in_pix[2], in_pix[3]);
    s1_sub_nxt[3] = pair_avg(in_pix[6], in_pix[7]);
  end

  // Weighted channel sums
  always_comb begin
    for (int i = 0; i < NUM_SUB; i++) begin
      s2_w_nxt[i] = luma_weight(s1_sub_r[i]);
    end
  end

  // Divide by 1000 through a reciprocal multiply
  always_comb begin
    logic [36:0] prod;
    s3_cell_nxt.sub = s2_sub_r;
    for (int i = 0; i < NUM_SUB; i++) begin
      prod = 37'(s2_w_r[i]) * 37'(RECIP_1000);
      s3_cell_nxt.luma[i] = prod[RECIP_SHIFT +: 8];
    end
  end

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  // Advance payload with its valid bit
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) s1_sub_r <= s1_sub_nxt;
    if (rdy[1] && v_r[0]) begin
      s2_sub_r <= s1_sub_r;
      s2_w_r   <= s2_w_nxt;
    end
    if (rdy[2] && v_r[1]) s3_cell_r <= s3_cell_nxt;
  end

  assign out_valid = v_r[2];
  assign out_cell  = s3_cell_r;

endmodule

// ===== sv/qgce_split.sv =====
module qgce_split
  import qgce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  lcell_t      in_cell,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_mask,
  output logic [13:0] out_glyph,
  output rgb_t        out_fore,
  output rgb_t        out_back
);

  logic [2:0]       v_r;
  logic [2:0]       rdy;
  logic [3:0]       s4_mask_r, s4_mask_nxt;
  cell_t            s4_sub_r;
  logic [3:0]       s5_mask_r;
  logic [2:0][9:0]  s5_fg_r, s5_fg_nxt;
  logic [2:0][9:0]  s5_bg_r, s5_bg_nxt;
  logic [2:0]       s5_fgn_r, s5_fgn_nxt;
  logic [2:0]       s5_bgn_r, s5_bgn_nxt;
  logic [3:0]       s6_mask_r;
  logic [13:0]      s6_glyph_r;
  rgb_t             s6_fore_r, s6_fore_nxt;
  rgb_t             s6_back_r, s6_back_nxt;

  assign rdy[2]   = !v_r[2] || out_ready;
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  // Threshold each luma against the floor of the mean
  always_comb begin
    logic [9:0] sum;
    logic [7:0] thr;
    sum = 10'(in_cell.luma[0]) + 10'(in_cell.luma[1])
        + 10'(in_cell.luma[2]) + 10'(in_cell.luma[3]);
    thr = sum[9:2];
    for (int i = 0; i < NUM_SUB; i++) begin
      s4_mask_nxt[i] = (in_cell.luma[i] >= thr);
    end
  end

  // Accumulate bright and dark colours and count them
  always_comb begin
    s5_fg_nxt  = '0;
    s5_bg_nxt  = '0;
    s5_fgn_nxt = '0;
    s5_bgn_nxt = '0;
    for (int i = 0; i < NUM_SUB; i++) begin
      if (s4_mask_r[i]) begin
        for (int c = 0; c < NUM_CH; c++) begin
          s5_fg_nxt[c] = s5_fg_nxt[c] + 10'(s4_sub_r[i][c]);
        end
        s5_fgn_nxt = s5_fgn_nxt + 3'd1;
      end else begin
        for (int c = 0; c < NUM_CH; c++) begin
          s5_bg_nxt[c] = s5_bg_nxt[c] + 10'(s4_sub_r[i][c]);
        end
        s5_bgn_nxt = s5_bgn_nxt + 3'd1;
      end
    end
  end

  // Floor means; an empty group reads as black
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s6_fore_nxt[c] = div_count(s5_fg_r[c], s5_fgn_r);
      s6_back_nxt[c] = div_count(s5_bg_r[c], s5_bgn_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      s4_mask_r <= s4_mask_nxt;
      s4_sub_r  <= in_cell.sub;
    end
    if (rdy[1] && v_r[0]) begin
      s5_mask_r <= s4_mask_r;
      s5_fg_r   <= s5_fg_nxt;
      s5_bg_r   <= s5_bg_nxt;
      s5_fgn_r  <= s5_fgn_nxt;
      s5_bgn_r  <= s5_bgn_nxt;
    end
    if (rdy[2] && v_r[1]) begin
      s6_mask_r  <= s5_mask_r;
      s6_glyph_r <= GLYPH_TABLE[s5_mask_r];
      s6_fore_r  <= s6_fore_nxt;
      s6_back_r  <= s6_back_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign out_mask  = s6_mask_r;
  assign out_glyph = s6_glyph_r;
  assign out_fore  = s6_fore_r;
  assign out_back  = s6_back_r;

endmodule

// ===== sv/quadrant_glyph_cell_encoder_top.sv =====
// Quadrant glyph cell encoder: takes one 2x4 cell of packed RGB pixels per word and
// returns the 2x2 bright mask, its quadrant glyph code point and the floor-mean
// foreground and background colours. The pipeline has six register stages (pair
// average, luma weighting, divide by 1000, threshold, colour sums, colour means), and
// one cell is taken every cycle while out_ready stays high. Back-pressure runs stage
// by stage: a stalled result holds its own stage and every full stage behind it,
// and in_ready stays high while any stage is empty.
module quadrant_glyph_cell_encoder_top
  import qgce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_pix_left_row0,
  input  logic [23:0] in_pix_left_row1,
  input  logic [23:0] in_pix_left_row2,
  input  logic [23:0] in_pix_left_row3,
  input  logic [23:0] in_pix_right_row0,
  input  logic [23:0] in_pix_right_row1,
  input  logic [23:0] in_pix_right_row2,
  input  logic [23:0] in_pix_right_row3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_quad_mask,
  output logic [13:0] out_glyph_code,
  output logic [7:0]  out_fore_red,
  output logic [7:0]  out_fore_green,
  output logic [7:0]  out_fore_blue,
  output logic [7:0]  out_back_red,
  output logic [7:0]  out_back_green,
  output logic [7:0]  out_back_blue
);

  rgb_t [NUM_PIX-1:0] pix;
  logic               mid_valid;
  logic               mid_ready;
  lcell_t             mid_cell;
  rgb_t               fore;
  rgb_t               back;

  // Gather the pixels: left column rows 0 to 3, then right column rows 0 to 3
  assign pix[0] = rgb_t'(in_pix_left_row0);
  assign pix[1] = rgb_t'(in_pix_left_row1);
  assign pix[2] = rgb_t'(in_pix_left_row2);
  assign pix[3] = rgb_t'(in_pix_left_row3);
  assign pix[4] = rgb_t'(in_pix_right_row0);
  assign pix[5] = rgb_t'(in_pix_right_row1);
  assign pix[6] = rgb_t'(in_pix_right_row2);
  assign pix[7] = rgb_t'(in_pix_right_row3);

  qgce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pix    (pix),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_cell  (mid_cell)
  );

  qgce_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_cell   (mid_cell),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_mask  (out_quad_mask),
    .out_glyph (out_glyph_code),
    .out_fore  (fore),
    .out_back  (back)
  );

  assign out_fore_red   = fore[2];
  assign out_fore_green = fore[1];
  assign out_fore_blue  = fore[0];
  assign out_back_red   = back[2];
  assign out_back_green = back[1];
  assign out_back_blue  = back[0];

endmodule

// ===== sv/qgce_checker.sv =====
module qgce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_quad_mask,
  input logic [13:0] out_glyph_code,
  input logic [7:0]  out_fore_red,
  input logic [7:0]  out_fore_green,
  input logic [7:0]  out_fore_blue,
  input logic [7:0]  out_back_red,
  input logic [7:0]  out_back_green,
  input logic [7:0]  out_back_blue
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quad_mask)
      && $stable(out_glyph_code) && $stable(out_fore_red) && $stable(out_fore_green)
      && $stable(out_fore_blue) && $stable(out_back_red) && $stable(out_back_green)
      && $stable(out_back_blue))
    else $error("stalled result word changed");

  // Drop all results through reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The brightest sub-pixel always reaches the threshold
  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_quad_mask != 4'd0)
    else $error("empty bright mask");

  // Full mask means no dark group, so black background, and full block glyph
  a_full_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quad_mask == 4'hF |-> out_back_red == 8'd0
      && out_back_green == 8'd0 && out_back_blue == 8'd0
      && out_glyph_code == 14'h2588)
    else $error("full mask without black background");

endmodule

bind quadrant_glyph_cell_encoder_top qgce_checker u_qgce_checker (.*);
